// ===== src/irse_pkg.sv =====
// ----------------------------------------------------------------------------
// irse_pkg: shared types and constants of the IR remote symbol encoder
// Holds command count, repeat count, register map and the symbol timing
// constants used by the front end, queue and symbol sequencer.
// ----------------------------------------------------------------------------
package irse_pkg;

  // burst shape
  localparam int REPEATS       = 2;   // frame copies per burst (1..3)
  localparam int COMMANDS      = 4;   // trigger bits in use (1..4)
  localparam int NUM_CODES     = 4;   // code registers kept
  localparam int CODE_W        = 16;
  localparam int COUNT_W       = 4;
  localparam int TICK_W        = 8;
  localparam int CMD_W         = 2;   // index into the code bank
  localparam int FRAME_SYMBOLS = 18;  // start, 16 data bits, gap
  localparam int SYM_W         = 5;   // index within a frame
  localparam int REP_W         = (REPEATS > 1) ? $clog2(REPEATS) : 1;
  localparam int GAP_UNITS     = 134;

  // symbol positions within a frame
  localparam logic [SYM_W-1:0] SYM_START = SYM_W'(0);
  localparam logic [SYM_W-1:0] SYM_GAP   = SYM_W'(FRAME_SYMBOLS - 1);
  localparam logic [REP_W-1:0] REP_LAST  = REP_W'(REPEATS - 1);

  localparam logic [CODE_W-1:0] DUTY_NEVER = 16'hFFFF;

  // queue between front end and sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_0      = 3'd0,
    REG_CODE_1      = 3'd1,
    REG_CODE_2      = 3'd2,
    REG_CODE_3      = 3'd3,
    REG_BASE_TICKS  = 3'd4,
    REG_COUNTER_MAX = 3'd5
  } cfg_reg_t;

  typedef logic [NUM_CODES-1:0][CODE_W-1:0] code_bank_t;

  // reset values of the configuration registers
  localparam logic [CODE_W-1:0]  RST_CODE_0      = 16'h5000;
  localparam logic [CODE_W-1:0]  RST_CODE_1      = 16'h50FA;
  localparam logic [CODE_W-1:0]  RST_CODE_2      = 16'h5054;
  localparam logic [CODE_W-1:0]  RST_CODE_3      = 16'h50A8;
  localparam logic [TICK_W-1:0]  RST_BASE_TICKS  = 8'd29;
  localparam logic [COUNT_W-1:0] RST_COUNTER_MAX = 4'd3;

  // timer reload values of one burst, minus one, in prescaled ticks
  typedef struct packed {
    logic [CODE_W-1:0] one_unit;
    logic [CODE_W-1:0] two_unit;
    logic [CODE_W-1:0] three_unit;
    logic [CODE_W-1:0] gap_unit;
  } timing_t;

endpackage

// ===== src/ir_remote_symbol_encoder.sv =====
// ----------------------------------------------------------------------------
// ir_remote_symbol_encoder: pulse-width IR remote burst encoder
// Turns a trigger word into a burst of timer reload pairs for a remote code.
// ----------------------------------------------------------------------------
// A trigger word selects the command of its lowest set bit; that command's
// rolling counter is added to its base code and the burst for that code is
// produced as 36 symbols (two frames of start, 16 data bits MSB first, gap),
// each a duty/period reload pair. A trigger word with no set bit is taken and
// produces nothing. The symbol sequencer emits one symbol per cycle while
// out_ready does not stall it; that sequencer is the only part that sets
// the rate. The front end decodes triggers combinationally and the queue
// holds up to two pending codes, so triggers are taken during a burst.
// Configuration registers (index: 0..3 base codes, 4 base_ticks,
// 5 counter_max) are written through the cfg port, which is always ready;
// write them only while no burst is pending or in flight.
module ir_remote_symbol_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_trigger_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_duty_reload,
  output logic [15:0] out_period_reload,
  output logic [15:0] out_code_sent,
  output logic        out_last_symbol,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  irse_pkg::code_bank_t          codes_r;
  logic [irse_pkg::TICK_W-1:0]   base_ticks_r;
  logic [irse_pkg::COUNT_W-1:0]  counter_max_r;

  logic                          q_push;
  logic [irse_pkg::CODE_W-1:0]   q_push_code;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_not_empty;
  logic [irse_pkg::CODE_W-1:0]   q_head_code;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[0]    <= irse_pkg::RST_CODE_0;
      codes_r[1]    <= irse_pkg::RST_CODE_1;
      codes_r[2]    <= irse_pkg::RST_CODE_2;
      codes_r[3]    <= irse_pkg::RST_CODE_3;
      base_ticks_r  <= irse_pkg::RST_BASE_TICKS;
      counter_max_r <= irse_pkg::RST_COUNTER_MAX;
    end else if (cfg_valid) begin
      case (irse_pkg::cfg_reg_t'(cfg_index))
        irse_pkg::REG_CODE_0:      codes_r[0]    <= cfg_data;
        irse_pkg::REG_CODE_1:      codes_r[1]    <= cfg_data;
        irse_pkg::REG_CODE_2:      codes_r[2]    <= cfg_data;
        irse_pkg::REG_CODE_3:      codes_r[3]    <= cfg_data;
        irse_pkg::REG_BASE_TICKS:  base_ticks_r  <= cfg_data[irse_pkg::TICK_W-1:0];
        irse_pkg::REG_COUNTER_MAX: counter_max_r <= cfg_data[irse_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  irse_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_trigger_bits (in_trigger_bits),
    .codes           (codes_r),
    .counter_max     (counter_max_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_code          (q_push_code)
  );

  irse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_code (q_push_code),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_code (q_head_code)
  );

  irse_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .base_ticks        (base_ticks_r),
    .q_not_empty       (q_not_empty),
    .q_code            (q_head_code),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty_reload   (out_duty_reload),
    .out_period_reload (out_period_reload),
    .out_code_sent     (out_code_sent),
    .out_last_symbol   (out_last_symbol)
  );

endmodule

// ===== src/irse_front.sv =====
// ----------------------------------------------------------------------------
// irse_front: trigger decode and rolling counters
// Picks the lowest requested command, advances its rolling counter and
// pushes the resulting code into the burst queue.
// ----------------------------------------------------------------------------
module irse_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [3:0]                   in_trigger_bits,
  input  irse_pkg::code_bank_t         codes,
  input  logic [irse_pkg::COUNT_W-1:0] counter_max,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [irse_pkg::CODE_W-1:0]  q_code
);

  logic [irse_pkg::COMMANDS-1:0][irse_pkg::COUNT_W-1:0] next_count_r;
  logic [irse_pkg::COMMANDS-1:0][irse_pkg::COUNT_W-1:0] next_count_nxt;
  logic [irse_pkg::CMD_W-1:0]   sel;
  logic                         hit;
  logic [irse_pkg::COUNT_W-1:0] cnt;

  // lowest set request bit wins
  always_comb begin
    sel = '0;
    hit = 1'b0;
    for (int i = irse_pkg::COMMANDS - 1; i >= 0; i--) begin
      if (in_trigger_bits[i]) begin
        sel = irse_pkg::CMD_W'(i);
        hit = 1'b1;
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && hit;

  // counter value in use, folded back to zero past the maximum
  always_comb begin
    cnt = next_count_r[sel];
    if (cnt > counter_max) begin
      cnt = '0;
    end
    next_count_nxt = next_count_r;
    if (q_push) begin
      next_count_nxt[sel] = cnt + irse_pkg::COUNT_W'(1);
    end
  end

  assign q_code = codes[sel] + irse_pkg::CODE_W'(cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_count_r <= '0;
    end else begin
      next_count_r <= next_count_nxt;
    end
  end

endmodule

// ===== src/irse_queue.sv =====
// ----------------------------------------------------------------------------
// irse_queue: short code queue
// Two-entry register queue that decouples trigger decode from symbol output.
// ----------------------------------------------------------------------------
module irse_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [irse_pkg::CODE_W-1:0] push_code,
  input  logic                        pop,
  output logic                        full,
  output logic                        not_empty,
  output logic [irse_pkg::CODE_W-1:0] head_code
);

  logic [irse_pkg::QUEUE_DEPTH-1:0][irse_pkg::CODE_W-1:0] entry_r;
  logic [irse_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [irse_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [irse_pkg::QCNT_W-1:0] count_r;
  logic [irse_pkg::QCNT_W-1:0] count_nxt;

  assign full      = (count_r == irse_pkg::QCNT_W'(irse_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_code = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + irse_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - irse_pkg::QCNT_W'(1);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + irse_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + irse_pkg::QPTR_W'(1);
      end
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_code;
    end
  end

endmodule

// ===== src/irse_seq.sv =====
// ----------------------------------------------------------------------------
// irse_seq: symbol sequencer
// Takes one code at a time from the queue and emits start, data and gap
// symbols of every frame copy, one symbol per cycle while the output is not
// stalled, through an output register.
// ----------------------------------------------------------------------------
module irse_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [irse_pkg::TICK_W-1:0] base_ticks,
  input  logic                        q_not_empty,
  input  logic [irse_pkg::CODE_W-1:0] q_code,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_duty_reload,
  output logic [15:0]                 out_period_reload,
  output logic [15:0]                 out_code_sent,
  output logic                        out_last_symbol
);

  logic                        busy_r;
  logic                        busy_nxt;
  logic [irse_pkg::SYM_W-1:0]  sym_r;
  logic [irse_pkg::SYM_W-1:0]  sym_nxt;
  logic [irse_pkg::REP_W-1:0]  rep_r;
  logic [irse_pkg::REP_W-1:0]  rep_nxt;
  logic [irse_pkg::CODE_W-1:0] code_r;
  irse_pkg::timing_t           tim_r;
  irse_pkg::timing_t           tim_new;
  logic                        out_valid_r;
  logic [15:0]                 duty_r;
  logic [15:0]                 period_r;
  logic [15:0]                 code_out_r;
  logic                        last_r;

  logic                        advance;
  logic                        emit;
  logic                        last_copy;
  logic                        burst_end;
  logic [irse_pkg::SYM_W-1:0]  bit_pos;
  logic [15:0]                 sym_duty;
  logic [15:0]                 sym_period;
  logic [irse_pkg::CODE_W-1:0] b_ext;
  logic [irse_pkg::CODE_W-1:0] gap_ticks;

  // timing for a new burst; the user keeps base_ticks static while a burst runs, the block does not enforce it
  assign b_ext     = irse_pkg::CODE_W'(base_ticks);
  assign gap_ticks = b_ext * irse_pkg::CODE_W'(irse_pkg::GAP_UNITS);
  always_comb begin
    tim_new.one_unit   = b_ext - irse_pkg::CODE_W'(1);
    tim_new.two_unit   = (b_ext << 1) - irse_pkg::CODE_W'(1);
    tim_new.three_unit = (b_ext << 1) + b_ext - irse_pkg::CODE_W'(1);
    tim_new.gap_unit   = gap_ticks - irse_pkg::CODE_W'(1);
  end

  assign advance   = !out_valid_r || out_ready;
  assign emit      = busy_r && advance;
  assign last_copy = (rep_r == irse_pkg::REP_LAST);
  assign burst_end = emit && last_copy && (sym_r == irse_pkg::SYM_GAP);
  assign q_pop     = q_not_empty && (!busy_r || burst_end);

  // data bit for symbols 1..16, MSB first
  assign bit_pos = irse_pkg::SYM_W'(16) - sym_r;

  // symbol decode
  always_comb begin
    if (sym_r == irse_pkg::SYM_START) begin
      sym_duty   = '0;
      sym_period = tim_r.three_unit;
    end else if (sym_r == irse_pkg::SYM_GAP) begin
      sym_duty   = last_copy ? tim_r.gap_unit : irse_pkg::DUTY_NEVER;
      sym_period = tim_r.gap_unit;
    end else if (code_r[bit_pos[3:0]]) begin
      sym_duty   = tim_r.two_unit;
      sym_period = tim_r.three_unit;
    end else begin
      sym_duty   = tim_r.one_unit;
      sym_period = tim_r.two_unit;
    end
  end

  // position within the burst
  always_comb begin
    busy_nxt = busy_r;
    sym_nxt  = sym_r;
    rep_nxt  = rep_r;
    if (emit) begin
      if (sym_r == irse_pkg::SYM_GAP) begin
        sym_nxt = '0;
        if (last_copy) begin
          rep_nxt  = '0;
          busy_nxt = 1'b0;
        end else begin
          rep_nxt = rep_r + irse_pkg::REP_W'(1);
        end
      end else begin
        sym_nxt = sym_r + irse_pkg::SYM_W'(1);
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      sym_nxt  = '0;
      rep_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sym_r       <= '0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sym_r  <= sym_nxt;
      rep_r  <= rep_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // burst and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      code_r <= q_code;
      tim_r  <= tim_new;
    end
    if (emit) begin
      duty_r     <= sym_duty;
      period_r   <= sym_period;
      code_out_r <= code_r;
      last_r     <= last_copy && (sym_r == irse_pkg::SYM_GAP);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_duty_reload   = duty_r;
  assign out_period_reload = period_r;
  assign out_code_sent     = code_out_r;
  assign out_last_symbol   = last_r;

endmodule

// ===== dv/tb_ir_remote_symbol_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_remote_symbol_encoder: self-checking bench for the IR burst encoder
// A queue-fed driver presents trigger words. At every accepted transfer the
// bench predicts the full burst of duty/period symbols. A monitor compares
// each received symbol against that prediction. Phases with directed and
// random register settings are separated by idle points, with random stalls
// on both channels outside quiet phases.
// ----------------------------------------------------------------------------
module tb_ir_remote_symbol_encoder;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 70;

  // indexes outside the register map, written to check they are ignored
  localparam logic [irse_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [irse_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [irse_pkg::CODE_W-1:0] duty;
    logic [irse_pkg::CODE_W-1:0] period;
    logic [irse_pkg::CODE_W-1:0] code;
    logic                        last;
  } symbol_t;

  logic                            clk             = 1'b0;
  logic                            rst_n           = 1'b0;
  logic                            in_valid        = 1'b0;
  logic                            in_ready;
  logic [3:0]                      in_trigger_bits = '0;
  logic                            out_valid;
  logic                            out_ready       = 1'b0;
  logic [15:0]                     out_duty_reload;
  logic [15:0]                     out_period_reload;
  logic [15:0]                     out_code_sent;
  logic                            out_last_symbol;
  logic                            cfg_valid       = 1'b0;
  logic                            cfg_ready;
  logic [irse_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [irse_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

  // shadow of the register file and the per-command press counters
  logic [irse_pkg::CODE_W-1:0]  code_bank [irse_pkg::NUM_CODES];
  logic [irse_pkg::TICK_W-1:0]  unit_ticks;
  logic [irse_pkg::COUNT_W-1:0] count_ceiling;
  logic [irse_pkg::COUNT_W-1:0] press_count [irse_pkg::NUM_CODES];

  symbol_t    burst_symbols_q [$];
  logic [3:0] pending_triggers_q [$];
  int         triggers_queued = 0;
  int         triggers_taken  = 0;
  int         errors          = 0;
  int         idle_cycles     = 0;
  int         in_gap          = 0;
  int         out_hold        = 0;
  bit         quiet           = 1'b0;

  ir_remote_symbol_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_trigger_bits   (in_trigger_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty_reload   (out_duty_reload),
    .out_period_reload (out_period_reload),
    .out_code_sent     (out_code_sent),
    .out_last_symbol   (out_last_symbol),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the symbols of one burst and advance the selected press counter.
  // No set bit among the command bits means no burst.
  function automatic void encode_burst(input logic [3:0] trig);
    int                           sel;
    logic [irse_pkg::COUNT_W-1:0] step;
    logic [irse_pkg::CODE_W-1:0]  code;
    logic [irse_pkg::CODE_W-1:0]  one_u, two_u, three_u, gap_u;
    bit                           final_copy;
    sel = -1;
    for (int i = irse_pkg::COMMANDS - 1; i >= 0; i--)
      if (trig[i]) sel = i;
    if (sel < 0) return;

    // counter past the ceiling restarts at zero; stored value wraps at 16
    step             = (press_count[sel] > count_ceiling) ? '0 : press_count[sel];
    press_count[sel] = step + 1'b1;
    code             = code_bank[sel] + irse_pkg::CODE_W'(step);

    // timings wrap modulo 2^16, so zero base ticks gives 0xFFFF-based values
    one_u   = irse_pkg::CODE_W'(int'(unit_ticks) - 1);
    two_u   = irse_pkg::CODE_W'(2 * int'(unit_ticks) - 1);
    three_u = irse_pkg::CODE_W'(3 * int'(unit_ticks) - 1);
    gap_u   = irse_pkg::CODE_W'(irse_pkg::GAP_UNITS * int'(unit_ticks) - 1);

    for (int r = 0; r < irse_pkg::REPEATS; r++) begin
      final_copy = (r == irse_pkg::REPEATS - 1);
      burst_symbols_q.push_back('{duty: '0, period: three_u, code: code, last: 1'b0});
      for (int b = irse_pkg::CODE_W - 1; b >= 0; b--) begin
        if (code[b]) begin
          burst_symbols_q.push_back('{duty: two_u, period: three_u, code: code, last: 1'b0});
        end else begin
          burst_symbols_q.push_back('{duty: one_u, period: two_u, code: code, last: 1'b0});
        end
      end
      // gap of an earlier copy never expires
      burst_symbols_q.push_back('{duty: final_copy ? gap_u : irse_pkg::DUTY_NEVER,
                                  period: gap_u, code: code, last: final_copy});
    end
  endfunction

  task automatic check_field(input string name, input logic [irse_pkg::CODE_W-1:0] want,
                             input logic [irse_pkg::CODE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // register shadow follows every write transfer
  always @(posedge clk) begin : register_shadow
    if (!rst_n) begin
      code_bank[0]  = irse_pkg::RST_CODE_0;
      code_bank[1]  = irse_pkg::RST_CODE_1;
      code_bank[2]  = irse_pkg::RST_CODE_2;
      code_bank[3]  = irse_pkg::RST_CODE_3;
      unit_ticks    = irse_pkg::RST_BASE_TICKS;
      count_ceiling = irse_pkg::RST_COUNTER_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        irse_pkg::REG_CODE_0:      code_bank[0]  = cfg_data;
        irse_pkg::REG_CODE_1:      code_bank[1]  = cfg_data;
        irse_pkg::REG_CODE_2:      code_bank[2]  = cfg_data;
        irse_pkg::REG_CODE_3:      code_bank[3]  = cfg_data;
        irse_pkg::REG_BASE_TICKS:  unit_ticks    = cfg_data[irse_pkg::TICK_W-1:0];
        irse_pkg::REG_COUNTER_MAX: count_ceiling = cfg_data[irse_pkg::COUNT_W-1:0];
        default: ;  // unmapped index has no effect
      endcase
    end
  end

  // trigger driver: pops pending words, predicts on each accepted transfer
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
      foreach (press_count[i]) press_count[i] = '0;
    end else begin
      if (in_valid && in_ready) begin
        encode_burst(in_trigger_bits);
        triggers_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_triggers_q.size() > 0) begin
          in_valid        <= 1'b1;
          in_trigger_bits <= pending_triggers_q.pop_front();
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // symbol monitor with random back-pressure
  always @(posedge clk) begin : monitor
    symbol_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (burst_symbols_q.size() == 0) begin
          $error("unexpected symbol: duty %h period %h code %h last %b",
                 out_duty_reload, out_period_reload, out_code_sent, out_last_symbol);
          errors++;
        end else begin
          want = burst_symbols_q.pop_front();
          check_field("duty_reload", want.duty, out_duty_reload);
          check_field("period_reload", want.period, out_period_reload);
          check_field("code_sent", want.code, out_code_sent);
          check_field("last_symbol", irse_pkg::CODE_W'(want.last),
                      irse_pkg::CODE_W'(out_last_symbol));
        end
      end
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        out_hold = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stop when no transfer of any kind happens for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_trigger(input logic [3:0] trig);
    pending_triggers_q.push_back(trig);
    triggers_queued++;
  endtask

  // returns at a rising edge once every trigger is taken and every symbol seen
  task automatic wait_drained();
    while (triggers_taken != triggers_queued || burst_symbols_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; caller lowers it afterwards
  task automatic write_reg(input logic [irse_pkg::CFG_IDX_W-1:0] idx,
                           input logic [irse_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic randomize_config();
    logic [irse_pkg::CFG_DATA_W-1:0] data;
    for (int i = 0; i < irse_pkg::NUM_CODES; i++) begin
      data = irse_pkg::CFG_DATA_W'($urandom);
      // codes near the top wrap when the counter is added
      if ($urandom_range(0, 3) == 0)
        data = 16'hFFFF - irse_pkg::CFG_DATA_W'($urandom_range(0, 15));
      write_reg(irse_pkg::CFG_IDX_W'(i), data);
    end
    data = irse_pkg::CFG_DATA_W'($urandom);
    case ($urandom_range(0, 4))
      0:       data[irse_pkg::TICK_W-1:0] = '0;
      1:       data[irse_pkg::TICK_W-1:0] = 8'd1;
      2:       data[irse_pkg::TICK_W-1:0] = '1;
      default: ;
    endcase
    write_reg(irse_pkg::REG_BASE_TICKS, data);
    write_reg(irse_pkg::REG_COUNTER_MAX, irse_pkg::CFG_DATA_W'($urandom));
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                irse_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : sequencer
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no request, each command alone, priority among bits,
    // then command 3 pressed past the default ceiling so its counter restarts
    push_trigger(4'h0); push_trigger(4'h1); push_trigger(4'h2); push_trigger(4'h4);
    push_trigger(4'h8); push_trigger(4'hF); push_trigger(4'hA); push_trigger(4'hC);
    push_trigger(4'h6); push_trigger(4'h8); push_trigger(4'h8); push_trigger(4'h8);
    push_trigger(4'h8); push_trigger(4'h0); push_trigger(4'h8);
    wait_drained();

    // extreme codes, longest timing, widest counter, unmapped indexes
    write_reg(irse_pkg::REG_CODE_0, 16'hFFFF);
    write_reg(irse_pkg::REG_CODE_1, 16'h0000);
    write_reg(irse_pkg::REG_CODE_2, 16'hAAAA);
    write_reg(irse_pkg::REG_CODE_3, 16'h5555);
    write_reg(irse_pkg::REG_BASE_TICKS, 16'h00FF);
    write_reg(irse_pkg::REG_COUNTER_MAX, 16'h000F);
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h1234);
    cfg_valid <= 1'b0;
    push_trigger(4'h1); push_trigger(4'h1); push_trigger(4'h1);
    push_trigger(4'h2); push_trigger(4'h4); push_trigger(4'h8); push_trigger(4'h0);
    wait_drained();

    // zero base ticks wraps all timings; zero ceiling pins every counter
    write_reg(irse_pkg::REG_BASE_TICKS, 16'hFF00);
    write_reg(irse_pkg::REG_COUNTER_MAX, 16'hFFF0);
    cfg_valid <= 1'b0;
    push_trigger(4'h1); push_trigger(4'h1); push_trigger(4'h8);

    // random phases, the last one without stalls
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      randomize_config();
      quiet = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        push_trigger(($urandom_range(0, 7) == 0) ? 4'h0 : 4'($urandom_range(1, 15)));
    end
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
